// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/cae_pkg.sv =====
`timescale 1ns / 1ps

package cae_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	// flag bit positions in the packed six-bit status field
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_V = 4;
	localparam int FLAG_N = 5;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
		OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
		OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
		OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
		OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
		OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
		OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
		OP_LDY = 6'd28, OP_LSR = 6'd29, OP_ORA = 6'd30, OP_PLA = 6'd31,
		OP_ROL = 6'd32, OP_ROR = 6'd33, OP_RTS = 6'd34, OP_SBC = 6'd35,
		OP_SEC = 6'd36, OP_SED = 6'd37, OP_SEI = 6'd38, OP_STA = 6'd39,
		OP_STX = 6'd40, OP_STY = 6'd41, OP_TAX = 6'd42, OP_TAY = 6'd43,
		OP_TSX = 6'd44, OP_TXA = 6'd45, OP_TXS = 6'd46, OP_TYA = 6'd47
	} op_t;

	typedef enum logic [3:0] {
		K_NONE, K_ADD, K_LOGIC, K_SHIFT, K_BIT, K_BRANCH, K_FLAG, K_CMP,
		K_STEP, K_MOVE, K_PLA, K_RTS
	} kind_t;

	typedef enum logic [2:0] {
		SRC_A, SRC_X, SRC_Y, SRC_SP, SRC_M
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_A, DST_X, DST_Y, DST_SP, DST_MEM
	} dst_t;

	// sub-operation codes, meaning depends on the kind
	localparam logic [1:0] ADD_PLAIN = 2'd0;
	localparam logic [1:0] ADD_INV   = 2'd1;
	localparam logic [1:0] LG_AND    = 2'd0;
	localparam logic [1:0] LG_EOR    = 2'd1;
	localparam logic [1:0] LG_ORA    = 2'd2;
	localparam logic [1:0] SH_ASL    = 2'd0;
	localparam logic [1:0] SH_LSR    = 2'd1;
	localparam logic [1:0] SH_ROL    = 2'd2;
	localparam logic [1:0] SH_ROR    = 2'd3;
	localparam logic [1:0] BR_C      = 2'd0;
	localparam logic [1:0] BR_Z      = 2'd1;
	localparam logic [1:0] BR_N      = 2'd2;
	localparam logic [1:0] BR_V      = 2'd3;
	localparam logic [1:0] FL_C      = 2'd0;
	localparam logic [1:0] FL_D      = 2'd1;
	localparam logic [1:0] FL_I      = 2'd2;
	localparam logic [1:0] FL_V      = 2'd3;
	localparam logic [1:0] STEP_INC  = 2'd0;
	localparam logic [1:0] STEP_DEC  = 2'd1;

	typedef struct packed {
		kind_t      kind;
		src_t       src;
		dst_t       dst;
		logic [1:0] sel;
		logic       pol;
		logic       nz;
		logic [7:0] operand;
		logic       acc_mode;
	} uop_t;

	typedef struct packed {
		logic valid;
		uop_t uop;
	} q_push_t;

	typedef struct packed {
		logic valid;
		uop_t uop;
	} q_head_t;

endpackage

// ===== rtl/cae_ifs.sv =====
`timescale 1ns / 1ps

interface cae_instr_if;
	logic       valid;
	logic       ready;
	logic [5:0] opcode;
	logic [7:0] operand;
	logic       acc_mode;

	modport source (output valid, output opcode, output operand, output acc_mode,
		input ready);
	modport sink (input valid, input opcode, input operand, input acc_mode,
		output ready);
endinterface

interface cae_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  mem_result;
	logic        br_taken;
	logic [7:0]  acc_out;
	logic [7:0]  x_out;
	logic [7:0]  y_out;
	logic [7:0]  sp_out;
	logic [5:0]  flags_out;
	logic [15:0] pc_out;

	modport source (output valid, output mem_result, output br_taken,
		output acc_out, output x_out, output y_out, output sp_out,
		output flags_out, output pc_out, input ready);
	modport sink (input valid, input mem_result, input br_taken,
		input acc_out, input x_out, input y_out, input sp_out,
		input flags_out, input pc_out, output ready);
endinterface

// ===== rtl/cae_front.sv =====
`timescale 1ns / 1ps

module cae_front (
	cae_instr_if.sink          instr,
	input  logic               q_ready,
	output cae_pkg::q_push_t   push
);
	import cae_pkg::*;

	uop_t u;

	assign instr.ready = q_ready;

	always_comb begin
		u          = '0;
		u.kind     = K_NONE;
		u.src      = SRC_M;
		u.dst      = DST_NONE;
		u.sel      = 2'd0;
		u.pol      = 1'b0;
		u.nz       = 1'b0;
		u.operand  = instr.operand;
		u.acc_mode = instr.acc_mode;
		unique case (op_t'(instr.opcode))
			OP_ADC: begin u.kind = K_ADD; u.sel = ADD_PLAIN; end
			OP_SBC: begin u.kind = K_ADD; u.sel = ADD_INV; end
			OP_AND: begin u.kind = K_LOGIC; u.sel = LG_AND; end
			OP_EOR: begin u.kind = K_LOGIC; u.sel = LG_EOR; end
			OP_ORA: begin u.kind = K_LOGIC; u.sel = LG_ORA; end
			OP_ASL: begin u.kind = K_SHIFT; u.sel = SH_ASL; end
			OP_LSR: begin u.kind = K_SHIFT; u.sel = SH_LSR; end
			OP_ROL: begin u.kind = K_SHIFT; u.sel = SH_ROL; end
			OP_ROR: begin u.kind = K_SHIFT; u.sel = SH_ROR; end
			OP_BCC: begin u.kind = K_BRANCH; u.sel = BR_C; u.pol = 1'b0; end
			OP_BCS: begin u.kind = K_BRANCH; u.sel = BR_C; u.pol = 1'b1; end
			OP_BEQ: begin u.kind = K_BRANCH; u.sel = BR_Z; u.pol = 1'b1; end
			OP_BNE: begin u.kind = K_BRANCH; u.sel = BR_Z; u.pol = 1'b0; end
			OP_BMI: begin u.kind = K_BRANCH; u.sel = BR_N; u.pol = 1'b1; end
			OP_BPL: begin u.kind = K_BRANCH; u.sel = BR_N; u.pol = 1'b0; end
			OP_BVC: begin u.kind = K_BRANCH; u.sel = BR_V; u.pol = 1'b0; end
			OP_BVS: begin u.kind = K_BRANCH; u.sel = BR_V; u.pol = 1'b1; end
			OP_BIT: u.kind = K_BIT;
			OP_CLC: begin u.kind = K_FLAG; u.sel = FL_C; u.pol = 1'b0; end
			OP_CLD: begin u.kind = K_FLAG; u.sel = FL_D; u.pol = 1'b0; end
			OP_CLI: begin u.kind = K_FLAG; u.sel = FL_I; u.pol = 1'b0; end
			OP_CLV: begin u.kind = K_FLAG; u.sel = FL_V; u.pol = 1'b0; end
			OP_SEC: begin u.kind = K_FLAG; u.sel = FL_C; u.pol = 1'b1; end
			OP_SED: begin u.kind = K_FLAG; u.sel = FL_D; u.pol = 1'b1; end
			OP_SEI: begin u.kind = K_FLAG; u.sel = FL_I; u.pol = 1'b1; end
			OP_CMP: begin u.kind = K_CMP; u.src = SRC_A; end
			OP_CPX: begin u.kind = K_CMP; u.src = SRC_X; end
			OP_CPY: begin u.kind = K_CMP; u.src = SRC_Y; end
			OP_DEC: begin
				u.kind = K_STEP; u.sel = STEP_DEC; u.src = SRC_M; u.dst = DST_MEM;
			end
			OP_DEX: begin
				u.kind = K_STEP; u.sel = STEP_DEC; u.src = SRC_X; u.dst = DST_X;
			end
			OP_DEY: begin
				u.kind = K_STEP; u.sel = STEP_DEC; u.src = SRC_Y; u.dst = DST_Y;
			end
			OP_INC: begin
				u.kind = K_STEP; u.sel = STEP_INC; u.src = SRC_M; u.dst = DST_MEM;
			end
			OP_INX: begin
				u.kind = K_STEP; u.sel = STEP_INC; u.src = SRC_X; u.dst = DST_X;
			end
			OP_INY: begin
				u.kind = K_STEP; u.sel = STEP_INC; u.src = SRC_Y; u.dst = DST_Y;
			end
			OP_LDA: begin u.kind = K_MOVE; u.src = SRC_M; u.dst = DST_A; u.nz = 1'b1; end
			OP_LDX: begin u.kind = K_MOVE; u.src = SRC_M; u.dst = DST_X; u.nz = 1'b1; end
			OP_LDY: begin u.kind = K_MOVE; u.src = SRC_M; u.dst = DST_Y; u.nz = 1'b1; end
			OP_STA: begin u.kind = K_MOVE; u.src = SRC_A; u.dst = DST_MEM; end
			OP_STX: begin u.kind = K_MOVE; u.src = SRC_X; u.dst = DST_MEM; end
			OP_STY: begin u.kind = K_MOVE; u.src = SRC_Y; u.dst = DST_MEM; end
			OP_TAX: begin u.kind = K_MOVE; u.src = SRC_A; u.dst = DST_X; u.nz = 1'b1; end
			OP_TAY: begin u.kind = K_MOVE; u.src = SRC_A; u.dst = DST_Y; u.nz = 1'b1; end
			OP_TSX: begin u.kind = K_MOVE; u.src = SRC_SP; u.dst = DST_X; u.nz = 1'b1; end
			OP_TXA: begin u.kind = K_MOVE; u.src = SRC_X; u.dst = DST_A; u.nz = 1'b1; end
			OP_TXS: begin u.kind = K_MOVE; u.src = SRC_X; u.dst = DST_SP; end
			OP_TYA: begin u.kind = K_MOVE; u.src = SRC_Y; u.dst = DST_A; u.nz = 1'b1; end
			OP_PLA: u.kind = K_PLA;
			OP_RTS: u.kind = K_RTS;
			// unused codes pass through with no effect
			default: u.kind = K_NONE;
		endcase
	end

	assign push.valid = instr.valid && q_ready;
	assign push.uop   = u;

endmodule

// ===== rtl/cae_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cae_queue #(
	parameter int DEPTH = cae_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cae_pkg::q_push_t push,
	output logic             ready,
	output cae_pkg::q_head_t head,
	input  logic             pop
);
	import cae_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	uop_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = count_q < CNT_W'(DEPTH);
	assign do_push  = push.valid && ready;
	assign do_pop   = pop && (count_q != '0);
	assign head.valid = count_q != '0;
	assign head.uop   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push.uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPL(a_cnt_max, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "queue overfilled")
	`ASSERT_NEXT(a_cnt_up, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue count did not grow")
	`ASSERT_NEXT(a_cnt_dn, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "queue count did not shrink")

endmodule

// ===== rtl/cae_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cae_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cae_pkg::q_head_t head,
	output logic             pop,
	cae_result_if.source     result
);
	import cae_pkg::*;

	logic [7:0]  a_q, x_q, y_q, sp_q;
	logic [5:0]  f_q;
	logic [15:0] pc_q;
	logic [7:0]  mem_q;
	logic        br_q;
	logic        out_valid_q;

	logic [7:0]  a_n, x_n, y_n, sp_n, mem_n;
	logic [5:0]  f_n;
	logic [15:0] pc_n;
	logic        br_n;
	logic        fire;

	uop_t        u;
	logic [7:0]  srcv;
	logic [7:0]  r;
	logic        nz_en;
	logic        wr_en;
	logic [7:0]  addend;
	logic [8:0]  total;
	logic [8:0]  diff;
	logic [7:0]  sv;
	logic        cin;
	logic        fb;

	assign u    = head.uop;
	// execute only when the result slot is free or being emptied
	assign fire = head.valid && (!out_valid_q || result.ready);
	assign pop  = fire;

	assign addend = (u.sel == ADD_INV) ? ~u.operand : u.operand;
	assign total  = {1'b0, a_q} + {1'b0, addend} + {8'd0, f_q[FLAG_C]};
	assign diff   = {1'b0, srcv} - {1'b0, u.operand};
	assign sv     = u.acc_mode ? a_q : u.operand;
	assign cin    = f_q[FLAG_C];

	always_comb begin
		unique case (u.src)
			SRC_A:   srcv = a_q;
			SRC_X:   srcv = x_q;
			SRC_Y:   srcv = y_q;
			SRC_SP:  srcv = sp_q;
			SRC_M:   srcv = u.operand;
			default: srcv = u.operand;
		endcase
	end

	always_comb begin
		unique case (u.sel)
			BR_C:    fb = f_q[FLAG_C];
			BR_Z:    fb = f_q[FLAG_Z];
			BR_N:    fb = f_q[FLAG_N];
			BR_V:    fb = f_q[FLAG_V];
			default: fb = 1'b0;
		endcase
	end

	always_comb begin
		a_n   = a_q;
		x_n   = x_q;
		y_n   = y_q;
		sp_n  = sp_q;
		f_n   = f_q;
		pc_n  = pc_q;
		mem_n = u.operand;
		br_n  = 1'b0;
		r     = 8'd0;
		nz_en = 1'b0;
		wr_en = 1'b0;
		case (u.kind)
			K_ADD: begin
				r = total[7:0];
				f_n[FLAG_V] = ((a_q[7] ^ r[7]) & (addend[7] ^ r[7]));
				f_n[FLAG_C] = total[8];
				a_n   = r;
				nz_en = 1'b1;
			end
			K_LOGIC: begin
				case (u.sel)
					LG_AND:  r = a_q & u.operand;
					LG_EOR:  r = a_q ^ u.operand;
					default: r = a_q | u.operand;
				endcase
				a_n   = r;
				nz_en = 1'b1;
			end
			K_SHIFT: begin
				case (u.sel)
					SH_ASL: begin f_n[FLAG_C] = sv[7]; r = {sv[6:0], 1'b0}; end
					SH_LSR: begin f_n[FLAG_C] = sv[0]; r = {1'b0, sv[7:1]}; end
					SH_ROL: begin f_n[FLAG_C] = sv[7]; r = {sv[6:0], cin}; end
					default: begin f_n[FLAG_C] = sv[0]; r = {cin, sv[7:1]}; end
				endcase
				if (u.acc_mode) begin
					a_n = r;
				end else begin
					mem_n = r;
				end
				nz_en = 1'b1;
			end
			K_BIT: begin
				f_n[FLAG_N] = u.operand[7];
				f_n[FLAG_V] = u.operand[6];
				f_n[FLAG_Z] = (a_q & u.operand) == 8'd0;
			end
			K_BRANCH: br_n = u.pol ? fb : ~fb;
			K_FLAG: begin
				case (u.sel)
					FL_C:    f_n[FLAG_C] = u.pol;
					FL_D:    f_n[FLAG_D] = u.pol;
					FL_I:    f_n[FLAG_I] = u.pol;
					default: f_n[FLAG_V] = u.pol;
				endcase
			end
			K_CMP: begin
				f_n[FLAG_C] = ~diff[8];
				f_n[FLAG_Z] = srcv == u.operand;
				f_n[FLAG_N] = diff[7];
			end
			K_STEP: begin
				r     = (u.sel == STEP_INC) ? srcv + 8'd1 : srcv - 8'd1;
				wr_en = 1'b1;
				nz_en = 1'b1;
			end
			K_MOVE: begin
				r     = srcv;
				wr_en = 1'b1;
				nz_en = u.nz;
			end
			K_PLA: begin
				r     = a_q;
				nz_en = 1'b1;
			end
			K_RTS: pc_n = pc_q + 16'd1;
			default: ;
		endcase
		if (wr_en) begin
			case (u.dst)
				DST_A:   a_n   = r;
				DST_X:   x_n   = r;
				DST_Y:   y_n   = r;
				DST_SP:  sp_n  = r;
				DST_MEM: mem_n = r;
				default: ;
			endcase
		end
		if (nz_en) begin
			f_n[FLAG_N] = r[7];
			f_n[FLAG_Z] = r == 8'd0;
		end
	end

	// registers change only together with a new result, so they drive the outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			sp_q        <= '0;
			f_q         <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				a_q  <= a_n;
				x_q  <= x_n;
				y_q  <= y_n;
				sp_q <= sp_n;
				f_q  <= f_n;
				pc_q <= pc_n;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mem_q <= mem_n;
			br_q  <= br_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mem_result   = mem_q;
	assign result.br_taken     = br_q;
	assign result.acc_out      = a_q;
	assign result.x_out        = x_q;
	assign result.y_out        = y_q;
	assign result.sp_out       = sp_q;
	assign result.flags_out    = f_q;
	assign result.pc_out       = pc_q;

	`ASSERT_NEXT(a_fire_valid, clk, arst_n, fire, out_valid_q, "executed item not presented")
	`ASSERT_NEXT(a_pc_rts, clk, arst_n, !(fire && u.kind == K_RTS), pc_q == $past(pc_q), "pc moved without rts")
	`ASSERT_NEXT(a_regs_hold, clk, arst_n, !fire, $stable(a_q) && $stable(f_q) && $stable(x_q), "state changed with no item")

endmodule

// ===== rtl/cpu8_alu_execute_unit.sv =====
// an accepted item is held in the decoded-item queue, then executed into the result register
// throughput: one item per cycle while the result side is ready; the execute step and its result register set the rate
// a short decoded-item queue lets the input keep accepting while a result waits
// reset: asynchronous, active low; clears A, X, Y, SP, PC, flags, queue and result valid
`timescale 1ns / 1ps

module cpu8_alu_execute_unit #(
	parameter int QUEUE_DEPTH = cae_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cae_instr_if.sink     instr,
	cae_result_if.source  result
);
	import cae_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_ready;
	logic    pop;

	cae_front u_front (
		.instr   (instr),
		.q_ready (q_ready),
		.push    (push)
	);

	cae_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (q_ready),
		.head   (head),
		.pop    (pop)
	);

	cae_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cae_pkg::*;

	typedef struct packed {
		logic [7:0]  mem;
		logic        br;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [5:0]  flags;
		logic [15:0] pc;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic gaps_on;
	int   mismatch_count = 0;

	// architectural state as the execute stage should hold it
	logic [7:0]  acc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [7:0]  sp_q;
	logic [5:0]  flag_q;
	logic [15:0] pc_q;

	exec_result_t pending_results[$];
	exec_result_t want;

	cae_instr_if  instr_ch ();
	cae_result_if result_ch ();

	cpu8_alu_execute_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] set_nz(input logic [7:0] v);
		flag_q[FLAG_N] = v[7];
		flag_q[FLAG_Z] = (v == 8'h00);
		return v;
	endfunction

	function automatic exec_result_t execute_instr(input logic [5:0] code,
			input logic [7:0] m, input logic am);
		exec_result_t r;
		op_t          op;
		logic [8:0]   total;
		logic [7:0]   addend;
		logic [7:0]   v;
		logic [7:0]   res;
		logic [5:0]   f0;
		logic         cin;
		op = op_t'(code);
		f0 = flag_q;
		r.mem = m;
		r.br = 1'b0;
		case (op)
		OP_ADC, OP_SBC: begin
			// subtract is add of the inverted operand, binary even with D set
			addend = (op == OP_SBC) ? ~m : m;
			total = {1'b0, acc_q} + {1'b0, addend} + {8'h00, flag_q[FLAG_C]};
			res = total[7:0];
			flag_q[FLAG_V] = ((acc_q ^ res) & (addend ^ res) & 8'h80) != 8'h00;
			flag_q[FLAG_C] = total[8];
			acc_q = set_nz(res);
		end
		OP_AND: acc_q = set_nz(acc_q & m);
		OP_EOR: acc_q = set_nz(acc_q ^ m);
		OP_ORA: acc_q = set_nz(acc_q | m);
		OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
			v = am ? acc_q : m;
			cin = flag_q[FLAG_C];
			if (op == OP_ASL || op == OP_ROL) begin
				flag_q[FLAG_C] = v[7];
				res = {v[6:0], (op == OP_ROL) ? cin : 1'b0};
			end else begin
				flag_q[FLAG_C] = v[0];
				res = {(op == OP_ROR) ? cin : 1'b0, v[7:1]};
			end
			res = set_nz(res);
			if (am)
				acc_q = res;
			else
				r.mem = res;
		end
		OP_BCC: r.br = !f0[FLAG_C];
		OP_BCS: r.br = f0[FLAG_C];
		OP_BEQ: r.br = f0[FLAG_Z];
		OP_BNE: r.br = !f0[FLAG_Z];
		OP_BMI: r.br = f0[FLAG_N];
		OP_BPL: r.br = !f0[FLAG_N];
		OP_BVC: r.br = !f0[FLAG_V];
		OP_BVS: r.br = f0[FLAG_V];
		OP_BIT: begin
			flag_q[FLAG_N] = m[7];
			flag_q[FLAG_V] = m[6];
			flag_q[FLAG_Z] = ((acc_q & m) == 8'h00);
		end
		OP_CLC: flag_q[FLAG_C] = 1'b0;
		OP_CLD: flag_q[FLAG_D] = 1'b0;
		OP_CLI: flag_q[FLAG_I] = 1'b0;
		OP_CLV: flag_q[FLAG_V] = 1'b0;
		OP_SEC: flag_q[FLAG_C] = 1'b1;
		OP_SED: flag_q[FLAG_D] = 1'b1;
		OP_SEI: flag_q[FLAG_I] = 1'b1;
		OP_CMP, OP_CPX, OP_CPY: begin
			v = (op == OP_CMP) ? acc_q : (op == OP_CPX) ? x_q : y_q;
			res = v - m;
			flag_q[FLAG_C] = (v >= m);
			flag_q[FLAG_Z] = (v == m);
			flag_q[FLAG_N] = res[7];
		end
		OP_DEC: r.mem = set_nz(m - 8'h01);
		OP_INC: r.mem = set_nz(m + 8'h01);
		OP_DEX: x_q = set_nz(x_q - 8'h01);
		OP_DEY: y_q = set_nz(y_q - 8'h01);
		OP_INX: x_q = set_nz(x_q + 8'h01);
		OP_INY: y_q = set_nz(y_q + 8'h01);
		OP_LDA: acc_q = set_nz(m);
		OP_LDX: x_q = set_nz(m);
		OP_LDY: y_q = set_nz(m);
		// the pull itself happens elsewhere, only the flags follow A here
		OP_PLA: res = set_nz(acc_q);
		OP_RTS: pc_q = pc_q + 16'h0001;
		OP_STA: r.mem = acc_q;
		OP_STX: r.mem = x_q;
		OP_STY: r.mem = y_q;
		OP_TAX: x_q = set_nz(acc_q);
		OP_TAY: y_q = set_nz(acc_q);
		OP_TSX: x_q = set_nz(sp_q);
		OP_TXA: acc_q = set_nz(x_q);
		OP_TXS: sp_q = x_q;
		OP_TYA: acc_q = set_nz(y_q);
		default: ;
		endcase
		r.a = acc_q;
		r.x = x_q;
		r.y = y_q;
		r.sp = sp_q;
		r.flags = flag_q;
		r.pc = pc_q;
		return r;
	endfunction

	// hold valid until the item is taken, with random gaps ahead of it
	task automatic issue_instr(input logic [5:0] code, input logic [7:0] m, input logic am);
		while (gaps_on && $urandom_range(99) < 10) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.opcode <= code;
		instr_ch.operand <= m;
		instr_ch.acc_mode <= am;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
		pending_results.push_back(execute_instr(code, m, am));
	endtask

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(9))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h7F;
		3: return 8'h80;
		4: return 8'h01;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic test_special_cases();
		issue_instr(OP_LDA, 8'h00, 1'b0);
		issue_instr(OP_LDA, 8'h7F, 1'b0);
		issue_instr(OP_ADC, 8'h01, 1'b0);
		issue_instr(OP_ADC, 8'hFF, 1'b0);
		// decimal flag must not change the adder
		issue_instr(OP_SED, 8'h00, 1'b0);
		issue_instr(OP_ADC, 8'h99, 1'b0);
		issue_instr(OP_SBC, 8'h01, 1'b0);
		issue_instr(OP_CLD, 8'h00, 1'b0);
		issue_instr(OP_SEC, 8'h00, 1'b0);
		issue_instr(OP_SBC, 8'hFF, 1'b0);
		issue_instr(OP_ASL, 8'hAA, 1'b1);
		issue_instr(OP_ROR, 8'h01, 1'b0);
		issue_instr(OP_ROL, 8'h80, 1'b0);
		issue_instr(OP_LSR, 8'h01, 1'b1);
		issue_instr(OP_PLA, 8'h55, 1'b0);
		issue_instr(OP_RTS, 8'h00, 1'b0);
		issue_instr(OP_LDX, 8'hFF, 1'b0);
		issue_instr(OP_TXS, 8'h00, 1'b0);
		issue_instr(OP_TSX, 8'h00, 1'b0);
		issue_instr(OP_INC, 8'hFF, 1'b0);
		issue_instr(OP_DEC, 8'h00, 1'b0);
		issue_instr(OP_BIT, 8'hC0, 1'b0);
		issue_instr(6'd48, 8'h5A, 1'b1);
		issue_instr(6'd63, 8'hA5, 1'b0);
	endtask

	task automatic test_opcode_sweep();
		for (int code = 0; code < 64; code++)
			issue_instr(6'(code), pick_operand(), 1'($urandom_range(1)));
	endtask

	// mostly legal mnemonics on random data, a few unused codes mixed in
	task automatic test_random_program(input int count);
		logic [5:0] code;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 5)
				code = 6'($urandom_range(63, 48));
			else
				code = 6'($urandom_range(47));
			issue_instr(code, pick_operand(), 1'($urandom_range(1)));
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item pending, actual mem %h acc %h",
					$time, result_ch.mem_result, result_ch.acc_out);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("mem_result", 16'(want.mem), 16'(result_ch.mem_result));
				check_field("br_taken", 16'(want.br), 16'(result_ch.br_taken));
				check_field("acc_out", 16'(want.a), 16'(result_ch.acc_out));
				check_field("x_out", 16'(want.x), 16'(result_ch.x_out));
				check_field("y_out", 16'(want.y), 16'(result_ch.y_out));
				check_field("sp_out", 16'(want.sp), 16'(result_ch.sp_out));
				check_field("flags_out", 16'(want.flags), 16'(result_ch.flags_out));
				check_field("pc_out", want.pc, result_ch.pc_out);
			end
		end
	end

	initial begin
		#1ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int drain;
		gaps_on = 1'b1;
		acc_q = 8'h00;
		x_q = 8'h00;
		y_q = 8'h00;
		sp_q = 8'h00;
		flag_q = 6'h00;
		pc_q = 16'h0000;
		arst_n <= 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.opcode <= 6'h00;
		instr_ch.operand <= 8'h00;
		instr_ch.acc_mode <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_opcode_sweep();
		test_random_program(1310);
		gaps_on <= 1'b0;
		test_random_program(250);
		gaps_on <= 1'b1;
		test_random_program(100);
		instr_ch.valid <= 1'b0;

		drain = 0;
		while (pending_results.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (5) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (pending_results.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
